>>> rtl/wpc_pkg.sv
// wpc_pkg: constants shared by the weighted path cost evaluator.
// Field widths, register map, word codes and reset values.
// No dependencies.
`default_nettype none

package wpc_pkg;

    localparam int NODES_DEFAULT       = 32;
    localparam int WEIGHT_BITS_DEFAULT = 16;

    localparam int NODE_BITS      = 5;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int COST_BITS      = 21;
    localparam int SUM_BITS       = 33;
    localparam int MISS_BITS      = 16;

    localparam logic [COST_BITS-1:0] COST_MAX           = 21'h1F_FFFF;
    localparam logic [MISS_BITS-1:0] MISSING_COST_RESET = 16'd4000;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_PATH = 1'b1;

    localparam int                  APB_ADDR_BITS = 3;
    localparam int                  APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_MISSING_EDGE_COST = 3'd0;

endpackage

`default_nettype wire

>>> rtl/weighted_path_cost.sv
// weighted_path_cost: route cost evaluator over a NODES x NODES edge table.
// A route total is registered in the table stage and then in the result queue before it appears on m_.
// Throughput: one word per cycle, the edge memory takes one read and one write per cycle;
// a two-entry result queue stalls s_ready only when both entries may be in use.
// Reset: synchronous; a clearing pass writes all NODES*NODES table entries
// (1024 entries by default) with s_ready low; the APB port works throughout.
// Depends on wpc_pkg.
`default_nettype none

module weighted_path_cost #(
    parameter int NODES       = wpc_pkg::NODES_DEFAULT,
    parameter int WEIGHT_BITS = wpc_pkg::WEIGHT_BITS_DEFAULT
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [wpc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire  [wpc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [wpc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready,

    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_mode,
    input  wire  [wpc_pkg::NODE_BITS-1:0]         s_edge_from,
    input  wire  [wpc_pkg::NODE_BITS-1:0]         s_edge_to,
    input  wire  [wpc_pkg::WEIGHT_IN_BITS-1:0]    s_edge_weight,
    input  wire  [wpc_pkg::NODE_BITS-1:0]         s_path_node,
    input  wire                                   s_path_last,

    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [wpc_pkg::COST_BITS-1:0]         m_path_cost
);

    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NSW   = $clog2(NODES + 1);
    localparam int MW    = WEIGHT_BITS + 1;

    typedef logic [wpc_pkg::COST_BITS-1:0] cost_t;
    typedef logic [wpc_pkg::SUM_BITS-1:0]  sum_t;

    // edge table: {present, weight}
    logic [MW-1:0] mem [DEPTH];

    logic [wpc_pkg::MISS_BITS-1:0] miss_reg, miss_next;

    logic            clr_busy_reg, clr_busy_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;

    logic [wpc_pkg::NODE_BITS-1:0] prev_reg, prev_next;
    logic [NSW-1:0]                seen_reg, seen_next;
    cost_t                         cost_reg, cost_next;

    logic                   stg_valid_reg, stg_valid_next;
    logic                   stg_path_reg;
    logic                   stg_last_reg;
    logic                   stg_pair_reg;
    logic                   stg_hit_reg;
    logic [AW-1:0]          stg_addr_reg;
    logic [WEIGHT_BITS-1:0] stg_weight_reg;

    logic                   fwd_hit_reg, fwd_hit_next;
    logic [MW-1:0]          fwd_data_reg;
    logic [MW-1:0]          rdata_reg;

    cost_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic                   accept;
    logic                   cfg_wr;
    logic                   is_path;
    logic                   edge_ok;
    logic                   counting;
    logic                   pair;
    logic                   pair_ok;
    logic [AW-1:0]          edge_addr;
    logic [AW-1:0]          path_addr;
    logic [AW-1:0]          rd_addr;
    logic [WEIGHT_BITS-1:0] w_in;

    logic [MW-1:0]          eff;
    logic                   present;
    logic                   wr_edge;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [MW-1:0]          mem_wdata;
    sum_t                   add_val;
    sum_t                   sum;
    cost_t                  sat;
    logic                   emit;
    logic                   pop;
    logic                   slot_ok;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == wpc_pkg::ADDR_MISSING_EDGE_COST);
    assign miss_next = cfg_wr ? pwdata[wpc_pkg::MISS_BITS-1:0] : miss_reg;

    always_comb begin
        if (paddr == wpc_pkg::ADDR_MISSING_EDGE_COST) begin
            prdata = wpc_pkg::APB_DATA_BITS'(miss_reg);
        end else begin
            prdata = '0;
        end
    end

    // input stage
    assign accept   = s_valid && s_ready;
    assign is_path  = (s_mode == wpc_pkg::MODE_PATH);
    assign w_in     = WEIGHT_BITS'(s_edge_weight);
    assign edge_ok  = (32'(s_edge_from) < NODES) && (32'(s_edge_to) < NODES);
    assign counting = (seen_reg < NSW'(NODES));
    assign pair     = counting && (seen_reg != '0);
    assign pair_ok  = (32'(prev_reg) < NODES) && (32'(s_path_node) < NODES);
    assign edge_addr = AW'(32'(s_edge_from) * 32'(NODES) + 32'(s_edge_to));
    assign path_addr = AW'(32'(prev_reg) * 32'(NODES) + 32'(s_path_node));
    assign rd_addr   = is_path ? path_addr : edge_addr;

    always_comb begin
        prev_next = prev_reg;
        seen_next = seen_reg;
        if (accept && is_path) begin
            if (s_path_last) begin
                prev_next = '0;
                seen_next = '0;
            end else if (counting) begin
                prev_next = s_path_node;
                seen_next = seen_reg + NSW'(1);
            end
        end
    end

    // table stage
    assign eff     = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign present = eff[WEIGHT_BITS];
    assign wr_edge = stg_valid_reg && !stg_path_reg && stg_hit_reg && !present;

    always_comb begin
        if (clr_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = wr_edge;
            mem_waddr = stg_addr_reg;
            mem_wdata = {1'b1, stg_weight_reg};
        end
    end

    assign fwd_hit_next   = accept && wr_edge && (stg_addr_reg == rd_addr);
    assign stg_valid_next = accept;

    always_comb begin
        if (!stg_pair_reg) begin
            add_val = '0;
        end else if (stg_hit_reg && present) begin
            add_val = wpc_pkg::SUM_BITS'(eff[WEIGHT_BITS-1:0]);
        end else begin
            add_val = wpc_pkg::SUM_BITS'(miss_reg);
        end
    end

    assign sum  = wpc_pkg::SUM_BITS'(cost_reg) + add_val;
    assign sat  = (sum > wpc_pkg::SUM_BITS'(wpc_pkg::COST_MAX))
                  ? wpc_pkg::COST_MAX : sum[wpc_pkg::COST_BITS-1:0];
    assign emit = stg_valid_reg && stg_path_reg && stg_last_reg;

    always_comb begin
        cost_next = cost_reg;
        if (stg_valid_reg && stg_path_reg) begin
            cost_next = stg_last_reg ? '0 : sat;
        end
    end

    // clearing pass
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    // result queue
    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_path_cost = q_reg[rd_ptr_reg];
    assign slot_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !emit);
    assign s_ready = !clr_busy_reg && slot_ok;

    always_comb begin
        wr_ptr_next = emit ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (emit && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!emit && pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_path_reg   <= is_path;
            stg_last_reg   <= s_path_last;
            stg_pair_reg   <= pair;
            stg_hit_reg    <= is_path ? pair_ok : edge_ok;
            stg_addr_reg   <= rd_addr;
            stg_weight_reg <= w_in;
            fwd_data_reg   <= mem_wdata;
        end
        if (emit) begin
            q_reg[wr_ptr_reg] <= sat;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            miss_reg      <= wpc_pkg::MISSING_COST_RESET;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            prev_reg      <= '0;
            seen_reg      <= '0;
            cost_reg      <= '0;
            stg_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= 2'd0;
        end else begin
            miss_reg      <= miss_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            prev_reg      <= prev_next;
            seen_reg      <= seen_next;
            cost_reg      <= cost_next;
            stg_valid_reg <= stg_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_weighted_path_cost.sv
// tb_weighted_path_cost: self-checking testbench for the route cost evaluator.
// Directed table then random phases, each total checked against a local predictor or a listed expected cost.
// Depends on wpc_pkg and weighted_path_cost.
`default_nettype none

module tb_weighted_path_cost;

    localparam int NODES          = wpc_pkg::NODES_DEFAULT;
    localparam int WEIGHT_BITS    = wpc_pkg::WEIGHT_BITS_DEFAULT;
    localparam int NODE_BITS      = wpc_pkg::NODE_BITS;
    localparam int WEIGHT_IN_BITS = wpc_pkg::WEIGHT_IN_BITS;
    localparam int COST_BITS      = wpc_pkg::COST_BITS;
    localparam int SUM_BITS       = wpc_pkg::SUM_BITS;
    localparam int MISS_BITS      = wpc_pkg::MISS_BITS;
    localparam int APB_ADDR_BITS  = wpc_pkg::APB_ADDR_BITS;
    localparam int APB_DATA_BITS  = wpc_pkg::APB_DATA_BITS;
    localparam int LIMIT          = 600000;
    localparam int PHASE_WORDS    = 200;
    localparam int SETTLE         = 4;

    typedef struct packed {
        logic                      mode;
        logic [NODE_BITS-1:0]      src;
        logic [NODE_BITS-1:0]      dst;
        logic [WEIGHT_IN_BITS-1:0] weight;
        logic [NODE_BITS-1:0]      node;
        logic                      last;
        logic                      typed;
        logic [COST_BITS-1:0]      cost;
    } stim_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_mode;
    logic [NODE_BITS-1:0]      s_edge_from;
    logic [NODE_BITS-1:0]      s_edge_to;
    logic [WEIGHT_IN_BITS-1:0] s_edge_weight;
    logic [NODE_BITS-1:0]      s_path_node;
    logic                      s_path_last;
    logic                      m_valid;
    logic                      m_ready;
    logic [COST_BITS-1:0]      m_path_cost;

    weighted_path_cost #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_edge_from   (s_edge_from),
        .s_edge_to     (s_edge_to),
        .s_edge_weight (s_edge_weight),
        .s_path_node   (s_path_node),
        .s_path_last   (s_path_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_path_cost   (m_path_cost)
    );

    // predictor state
    bit                        edge_known [NODES*NODES];
    logic [WEIGHT_IN_BITS-1:0] edge_cost  [NODES*NODES];
    logic [NODE_BITS-1:0]      prev_node;
    logic [COST_BITS-1:0]      route_sum;
    logic [5:0]                route_len;
    logic [MISS_BITS-1:0]      miss_cost;

    logic [COST_BITS-1:0]      route_totals [$];
    stim_row_t                 dir_rows [$];
    int                        mismatches;
    int                        cycles;
    int                        ready_hold;
    bit                        calm;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic stim_row_t edge_row(input int src, input int dst, input int weight,
                                           input bit last);
        stim_row_t w;
        w        = '0;
        w.mode   = wpc_pkg::MODE_EDGE;
        w.src    = NODE_BITS'(src);
        w.dst    = NODE_BITS'(dst);
        w.weight = WEIGHT_IN_BITS'(weight);
        w.node   = NODE_BITS'($urandom);
        w.last   = last;
        return w;
    endfunction

    function automatic stim_row_t path_row(input int node, input bit last, input bit typed,
                                           input int cost);
        stim_row_t w;
        w        = '0;
        w.mode   = wpc_pkg::MODE_PATH;
        w.src    = NODE_BITS'($urandom);
        w.dst    = NODE_BITS'($urandom);
        w.weight = WEIGHT_IN_BITS'($urandom);
        w.node   = NODE_BITS'(node);
        w.last   = last;
        w.typed  = typed;
        w.cost   = COST_BITS'(cost);
        return w;
    endfunction

    task automatic advance_route(input stim_row_t w, output bit done,
                                 output logic [COST_BITS-1:0] total);
        int                   idx;
        logic [SUM_BITS-1:0]  sum;
        logic [MISS_BITS-1:0] hop;
        done  = 1'b0;
        total = '0;
        if (w.mode == wpc_pkg::MODE_EDGE) begin
            idx = int'(w.src) * NODES + int'(w.dst);
            if (int'(w.src) < NODES && int'(w.dst) < NODES && !edge_known[idx]) begin
                edge_known[idx] = 1'b1;
                edge_cost[idx]  = w.weight
                                  & WEIGHT_IN_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);
            end
        end else begin
            if (route_len < NODES) begin
                if (route_len > 0) begin
                    idx = int'(prev_node) * NODES + int'(w.node);
                    hop = miss_cost;
                    if (int'(prev_node) < NODES && int'(w.node) < NODES && edge_known[idx])
                        hop = edge_cost[idx];
                    sum = SUM_BITS'(route_sum) + SUM_BITS'(hop);
                    route_sum = (sum > SUM_BITS'(wpc_pkg::COST_MAX))
                                ? wpc_pkg::COST_MAX : sum[COST_BITS-1:0];
                end
                prev_node = w.node;
                route_len++;
            end
            if (w.last) begin
                done      = 1'b1;
                total     = route_sum;
                route_sum = '0;
                prev_node = '0;
                route_len = '0;
            end
        end
    endtask

    // entered just after a rising edge; returns just after the accepting edge
    task automatic send_word(input stim_row_t w);
        int                   gap;
        bit                   done;
        logic [COST_BITS-1:0] total;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= w.mode;
        s_edge_from   <= w.src;
        s_edge_to     <= w.dst;
        s_edge_weight <= w.weight;
        s_path_node   <= w.node;
        s_path_last   <= w.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_route(w, done, total);
        if (done) route_totals.push_back(w.typed ? w.cost : total);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (route_totals.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_miss_cost(input logic [MISS_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wpc_pkg::ADDR_MISSING_EDGE_COST;
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        miss_cost = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== APB_DATA_BITS'(miss_cost))
            report_mismatch("missing_edge_cost readback", prdata, APB_DATA_BITS'(miss_cost));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic stim_row_t rand_edge();
        bit hot;
        int r;
        int weight;
        hot = $urandom_range(0, 9) < 7;
        r   = $urandom_range(0, 9);
        weight = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(0, 65535);
        return edge_row(hot ? $urandom_range(0, 7) : $urandom_range(0, 31),
                        hot ? $urandom_range(0, 7) : $urandom_range(0, 31),
                        weight, $urandom_range(0, 1));
    endfunction

    task automatic run_phase(input logic [MISS_BITS-1:0] cost, input bit quiet);
        int sent;
        int len;
        int r;
        bit hot;
        drain();
        write_miss_cost(cost);
        calm = quiet;
        sent = 0;
        while (sent < PHASE_WORDS) begin
            if ($urandom_range(0, 99) < 15) begin
                send_word(rand_edge());
                sent++;
            end else begin
                r   = $urandom_range(0, 99);
                len = (r < 70) ? $urandom_range(2, 6) : (r < 85) ? 1 :
                      (r < 95) ? $urandom_range(7, 31) : $urandom_range(32, 40);
                hot = $urandom_range(0, 9) < 8;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_word(rand_edge());
                        sent++;
                    end
                    send_word(path_row(hot ? $urandom_range(0, 7) : $urandom_range(0, 31),
                                       k == len - 1, 1'b0, 0));
                    sent++;
                end
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (route_totals.size() == 0) begin
                report_mismatch("unexpected path_cost", 32'(m_path_cost), 0);
            end else begin
                if (m_path_cost !== route_totals[0])
                    report_mismatch("path_cost", 32'(m_path_cost), 32'(route_totals[0]));
                void'(route_totals.pop_front());
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    initial begin
        mismatches    = 0;
        calm          = 1'b0;
        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_valid       <= 1'b0;
        s_mode        <= wpc_pkg::MODE_EDGE;
        s_edge_from   <= '0;
        s_edge_to     <= '0;
        s_edge_weight <= '0;
        s_path_node   <= '0;
        s_path_last   <= 1'b0;
        m_ready       <= 1'b0;
        prev_node     = '0;
        route_sum     = '0;
        route_len     = '0;
        miss_cost     = wpc_pkg::MISSING_COST_RESET;

        dir_rows.push_back(path_row(0, 1'b1, 1'b1, 0));
        dir_rows.push_back(path_row(0, 1'b0, 1'b0, 0));
        dir_rows.push_back(path_row(1, 1'b1, 1'b1, 4000));
        dir_rows.push_back(edge_row(0, 1, 16'hFFFF, 1'b1));
        dir_rows.push_back(edge_row(0, 1, 5, 1'b0));
        dir_rows.push_back(path_row(0, 1'b0, 1'b0, 0));
        dir_rows.push_back(path_row(1, 1'b1, 1'b1, 65535));
        dir_rows.push_back(edge_row(31, 31, 0, 1'b0));
        dir_rows.push_back(path_row(31, 1'b0, 1'b0, 0));
        dir_rows.push_back(path_row(31, 1'b1, 1'b1, 0));
        dir_rows.push_back(edge_row(31, 0, 1234, 1'b0));
        dir_rows.push_back(path_row(31, 1'b0, 1'b0, 0));
        dir_rows.push_back(path_row(0, 1'b0, 1'b0, 0));
        dir_rows.push_back(path_row(1, 1'b1, 1'b1, 1234 + 65535));
        dir_rows.push_back(edge_row(10, 21, 16'hAAAA, 1'b0));
        dir_rows.push_back(edge_row(21, 10, 16'h5555, 1'b1));
        dir_rows.push_back(path_row(10, 1'b0, 1'b0, 0));
        dir_rows.push_back(edge_row(10, 21, 16'h1111, 1'b0));
        dir_rows.push_back(path_row(21, 1'b0, 1'b0, 0));
        dir_rows.push_back(path_row(10, 1'b0, 1'b0, 0));
        dir_rows.push_back(path_row(5, 1'b1, 1'b0, 0));
        dir_rows.push_back(path_row(7, 1'b1, 1'b1, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_word(dir_rows[i]);

        run_phase(16'd0, 1'b0);
        run_phase(16'hFFFF, 1'b1);
        run_phase(MISS_BITS'($urandom), 1'b0);
        run_phase(16'd1, 1'b0);
        run_phase(wpc_pkg::MISSING_COST_RESET, 1'b0);

        drain();
        if (route_totals.size() != 0)
            report_mismatch("path_cost words outstanding", route_totals.size(), 0);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/wpc_pkg.sv
rtl/weighted_path_cost.sv
dv/tb_weighted_path_cost.sv
